[rtl/core/epoch_to_calendar_date_top_defines.svh]
// Assertion helpers shared by the RTL. Each expands to one labeled concurrent
// assertion clocked on clk and held off while arst_n is low.
`ifndef EPOCH_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_TOP_DEFINES_SVH

// Same-cycle implication.
`define E2CD_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("e2cd assertion failed");

// Next-cycle implication.
`define E2CD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("e2cd assertion failed");

`endif

[rtl/core/e2cd_pkg.sv]
`timescale 1ns / 1ps

package e2cd_pkg;

	// Register map (byte addresses)
	localparam logic [1:0] REG_UTC_OFFSET_ADDR = 2'd0;
	localparam logic signed [4:0] UTC_OFFSET_RESET = -5'sd4;

	// Reciprocal constants: q = (x * RECIP) >> SHIFT, exact over the operand range
	localparam logic [26:0] DAY_RECIP   = 27'd101806633; // 1/675, x < 2^26
	localparam int          DAY_SHIFT   = 36;
	localparam logic [16:0] CYCLE_RECIP = 17'd91868;     // 1/1461, x < 2^16
	localparam int          CYCLE_SHIFT = 27;
	localparam logic [12:0] HOUR_RECIP  = 13'd4661;      // 1/225, x < 5400
	localparam int          HOUR_SHIFT  = 20;
	localparam logic [10:0] MIN_RECIP   = 11'd1093;      // 1/15, x < 900
	localparam int          MIN_SHIFT   = 14;

	localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
	localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;
	localparam logic [11:0] CYCLE_BASE_YEAR   = 12'd1968;

	// First day of each month (0-based day of year), common year
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [29:0] nanosecond;
	} date_t;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
	} md_t;

	// Month and day of month from the 0-based day of year
	function automatic md_t month_day(input logic [8:0] doy, input logic leap);
		md_t        res;
		logic [8:0] st;
		logic [8:0] base;
		res.month = 4'd1;
		base      = 9'd0;
		for (int i = 1; i < 12; i++) begin
			st = MONTH_START[i] + ((leap && i >= 2) ? 9'd1 : 9'd0);
			if (doy >= st) begin
				res.month = 4'(i + 1);
				base      = st;
			end
		end
		res.day = 5'(doy - base + 9'd1);
		return res;
	endfunction

endpackage

[rtl/core/e2cd_pipe.sv]
`timescale 1ns / 1ps

module e2cd_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         epoch_seconds,
	input  logic [29:0]         nanoseconds,
	input  logic signed [4:0]   utc_offset_hours,
	output logic                out_valid,
	input  logic                out_ready,
	output e2cd_pkg::date_t     date
);
	import e2cd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// stall ripples back only through occupied stages
	assign en_s7 = !v_s7 || out_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_ready  = en_s1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: apply offset, clamp below epoch
	logic signed [33:0] off_sec;
	logic signed [33:0] local_sum;
	logic [32:0]        t_s1;
	logic [29:0]        ns_s1;

	assign off_sec   = 34'(utc_offset_hours) * 34'sd3600;
	assign local_sum = signed'({2'b00, epoch_seconds}) + off_sec;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			t_s1  <= local_sum[33] ? 33'd0 : local_sum[32:0];
			ns_s1 <= nanoseconds;
		end
	end

	// stage 2: days = t / 86400 = (t >> 7) / 675
	logic [52:0] day_prod;
	logic [15:0] days_s2;
	logic [32:0] t_s2;
	logic [29:0] ns_s2;

	assign day_prod = 53'(t_s1[32:7]) * 53'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			days_s2 <= day_prod[DAY_SHIFT +: 16];
			t_s2    <= t_s1;
			ns_s2   <= ns_s1;
		end
	end

	// stage 3: seconds of day; four-year cycle count from 1968
	logic [25:0] day_sec_hi;
	logic [32:0] sod_full;
	logic [15:0] dp;
	logic [32:0] cyc_prod;
	logic [16:0] sod_s3;
	logic [15:0] dp_s3;
	logic [5:0]  c_s3;
	logic [29:0] ns_s3;

	assign day_sec_hi = 26'(days_s2) * 26'd675;
	assign sod_full   = t_s2 - {day_sec_hi, 7'b0};
	assign dp         = days_s2 + DAYS_1968_TO_1970;
	assign cyc_prod   = 33'(dp) * 33'(CYCLE_RECIP);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sod_s3 <= sod_full[16:0];
			dp_s3  <= dp;
			c_s3   <= cyc_prod[CYCLE_SHIFT +: 6];
			ns_s3  <= ns_s2;
		end
	end

	// stage 4: hour; day within cycle
	logic [25:0] hr_prod;
	logic [16:0] cyc_days;
	logic [15:0] r_full;
	logic [16:0] sod_s4;
	logic [4:0]  hour_s4;
	logic [5:0]  c_s4;
	logic [10:0] r_s4;
	logic [29:0] ns_s4;

	assign hr_prod  = 26'(sod_s3[16:4]) * 26'(HOUR_RECIP);
	assign cyc_days = 17'(c_s3) * 17'(DAYS_PER_CYCLE);
	assign r_full   = dp_s3 - cyc_days[15:0];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sod_s4  <= sod_s3;
			hour_s4 <= hr_prod[HOUR_SHIFT +: 5];
			c_s4    <= c_s3;
			r_s4    <= r_full[10:0];
			ns_s4   <= ns_s3;
		end
	end

	// stage 5: seconds of hour; year and day of year
	logic [16:0] rem_full;
	logic [1:0]  yi;
	logic [10:0] ybase;
	logic [10:0] doy_full;
	logic [11:0] rem_s5;
	logic [4:0]  hour_s5;
	logic [11:0] year_s5;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [29:0] ns_s5;

	assign rem_full = sod_s4 - 17'(hour_s4) * 17'd3600;

	// cycle: leap year of 366 days, then three years of 365
	always_comb begin
		if (r_s4 >= 11'd1096) begin
			yi    = 2'd3;
			ybase = 11'd1096;
		end else if (r_s4 >= 11'd731) begin
			yi    = 2'd2;
			ybase = 11'd731;
		end else if (r_s4 >= 11'd366) begin
			yi    = 2'd1;
			ybase = 11'd366;
		end else begin
			yi    = 2'd0;
			ybase = 11'd0;
		end
	end

	assign doy_full = r_s4 - ybase;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rem_s5  <= rem_full[11:0];
			hour_s5 <= hour_s4;
			year_s5 <= CYCLE_BASE_YEAR + {4'b0, c_s4, 2'b00} + 12'(yi);
			doy_s5  <= doy_full[8:0];
			leap_s5 <= (yi == 2'd0);
			ns_s5   <= ns_s4;
		end
	end

	// stage 6: minute; month and day
	logic [20:0] min_prod;
	logic [11:0] rem_s6;
	logic [5:0]  minute_s6;
	logic [4:0]  hour_s6;
	logic [11:0] year_s6;
	md_t         md_s6;
	logic [29:0] ns_s6;

	assign min_prod = 21'(rem_s5[11:2]) * 21'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			rem_s6    <= rem_s5;
			minute_s6 <= min_prod[MIN_SHIFT +: 6];
			hour_s6   <= hour_s5;
			year_s6   <= year_s5;
			md_s6     <= month_day(doy_s5, leap_s5);
			ns_s6     <= ns_s5;
		end
	end

	// stage 7: second; output register
	logic [11:0] sec_full;
	date_t       date_s7;

	assign sec_full = rem_s6 - 12'(minute_s6) * 12'd60;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			date_s7.year       <= year_s6;
			date_s7.month      <= md_s6.month;
			date_s7.day        <= md_s6.day;
			date_s7.hour       <= hour_s6;
			date_s7.minute     <= minute_s6;
			date_s7.second     <= sec_full[5:0];
			date_s7.nanosecond <= ns_s6;
		end
	end

	assign date = date_s7;

endmodule

[rtl/core/epoch_to_calendar_date_top.sv]
// Unix epoch to local calendar date. Each epoch_valid/epoch_ready transaction
// carries epoch seconds plus a nanosecond count; the block adds the signed
// whole-hour offset in register utc_offset_hours (address 0, reset -4), and
// returns local year, month, day, hour, minute and second, with the
// nanoseconds copied through untouched, as one date_valid/date_ready
// transaction. A local time before 1970 clamps to 1970-01-01 00:00:00. Every
// fourth year is leap, which is exact through 2099 (2100 is treated as leap).
// Throughput is one transaction per clock unless the output stalls. The
// seven-stage pipeline does the divides by 86400, 1461, 3600 and 60 as
// reciprocal multiplies, one per stage. A stalled output backs up only the
// occupied stages, so bubbles are squeezed out before epoch_ready drops.
// Write utc_offset_hours only while no transaction is in flight.
`timescale 1ns / 1ps

module epoch_to_calendar_date_top (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// epoch input
	input  logic        epoch_valid,
	output logic        epoch_ready,
	input  logic [31:0] epoch_seconds,
	input  logic [29:0] nanoseconds,
	// date output
	output logic        date_valid,
	input  logic        date_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [29:0] nanosecond
);
	import e2cd_pkg::*;

	`include "epoch_to_calendar_date_top_defines.svh"

	// ---- register port ----
	logic signed [4:0] utc_offset_hours_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_UTC_OFFSET_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utc_offset_hours_q <= UTC_OFFSET_RESET;
		end else if (cfg_wr) begin
			utc_offset_hours_q <= signed'(pwdata[4:0]);
		end
	end

	// read back sign-extended
	assign prdata = (paddr == REG_UTC_OFFSET_ADDR) ? 32'(utc_offset_hours_q) : 32'd0;

	// ---- conversion pipeline ----
	date_t date;

	e2cd_pipe u_pipe (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (epoch_valid),
		.in_ready         (epoch_ready),
		.epoch_seconds    (epoch_seconds),
		.nanoseconds      (nanoseconds),
		.utc_offset_hours (utc_offset_hours_q),
		.out_valid        (date_valid),
		.out_ready        (date_ready),
		.date             (date)
	);

	assign year       = date.year;
	assign month      = date.month;
	assign day        = date.day;
	assign hour       = date.hour;
	assign minute     = date.minute;
	assign second     = date.second;
	assign nanosecond = date.nanosecond;

	// ---- checks ----
	// month/day lookup always lands on a real calendar slot
	`E2CD_ASSERT_HOLDS(a_md_range, date_valid, (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= 5'd31))
	// time-of-day split and year base stay in range
	`E2CD_ASSERT_HOLDS(a_tod_range, date_valid, (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59) && (year >= 12'd1970))
	// input backs up only behind a stalled, occupied output
	`E2CD_ASSERT_HOLDS(a_stall_src, !epoch_ready, date_valid && !date_ready)
	// offset write lands as written
	`E2CD_ASSERT_NEXT(a_cfg_wr, cfg_wr, utc_offset_hours_q == signed'($past(pwdata[4:0])))

endmodule

[sim/tb_epoch_to_calendar_date_top.sv]
`timescale 1ns / 1ps

module tb_epoch_to_calendar_date_top;
	import e2cd_pkg::*;

	// Calendar constants used by the date predictor
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int EPOCH_YEAR    = 1970;
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Day-of-year marks used to aim random epochs at year and month rollovers
	localparam int YEAR_MARK_DAYS [5] = '{0, 31, 59, 60, 365};

	// Idle clocks after a drain, as slack before a register write
	localparam int PIPE_SETTLE     = 16;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RAND_PHASES     = 6;
	localparam int ITEMS_PER_PHASE = 325;

	// Directed stimulus row. Where typed is set, the expected date is given in
	// the row itself (clamp cases and other hand-worked dates); nanoseconds
	// always echo the input. Other rows go through the predictor.
	typedef struct packed {
		logic signed [4:0] offset;
		logic [31:0]       secs;
		logic [29:0]       ns;
		logic              typed;
		logic [11:0]       y;
		logic [3:0]        mo;
		logic [4:0]        d;
		logic [4:0]        h;
		logic [5:0]        mi;
		logic [5:0]        s;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// reset offset of -4 h
		'{-4, 0, 0, 1, 1970, 1, 1, 0, 0, 0},                 // clamps below 1970
		'{-4, 14399, 999999999, 1, 1970, 1, 1, 0, 0, 0},     // one second short
		'{-4, 14400, 30'h3FFFFFFF, 1, 1970, 1, 1, 0, 0, 0},  // exactly local zero
		'{-4, 100799, 0, 1, 1970, 1, 1, 23, 59, 59},         // last second of day one
		'{-4, 100800, 1, 1, 1970, 1, 2, 0, 0, 0},            // day rollover
		'{-4, 32'hFFFFFFFF, 30'h3FFFFFFF, 0, 0, 0, 0, 0, 0, 0},
		'{-4, 4102444799, 0, 0, 0, 0, 0, 0, 0, 0},           // end of 2099 UTC
		'{-4, 951796800, 0, 0, 0, 0, 0, 0, 0, 0},            // leap day 2000
		'{-4, 946699199, 0, 0, 0, 0, 0, 0, 0, 0},            // last second of 1999
		'{-4, 978235200, 0, 0, 0, 0, 0, 0, 0, 0},            // Dec 31 of a leap year
		'{-4, 4107542400, 0, 0, 0, 0, 0, 0, 0, 0},           // 2100 taken as leap
		'{-4, 32'hAAAAAAAA, 30'h15555555, 0, 0, 0, 0, 0, 0, 0},
		'{-4, 32'h55555555, 30'h2AAAAAAA, 0, 0, 0, 0, 0, 0, 0},
		// most negative offset
		'{-16, 0, 123, 1, 1970, 1, 1, 0, 0, 0},
		'{-16, 57600, 7, 1, 1970, 1, 1, 0, 0, 0},
		'{-16, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
		// most positive offset
		'{15, 0, 0, 1, 1970, 1, 1, 15, 0, 0},
		'{15, 32'hFFFFFFFF, 30'h3FFFFFFF, 0, 0, 0, 0, 0, 0, 0}, // past 2100
		'{15, 31482000, 0, 1, 1971, 1, 1, 0, 0, 0},          // year rollover
		// legal zone extremes
		'{-12, 43199, 5, 1, 1970, 1, 1, 0, 0, 0},
		'{14, 0, 0, 1, 1970, 1, 1, 14, 0, 0},
		'{14, 68119200, 0, 0, 0, 0, 0, 0, 0, 0},             // leap day 1972
		// UTC
		'{0, 0, 0, 1, 1970, 1, 1, 0, 0, 0},
		'{0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        epoch_valid = 1'b0;
	logic        epoch_ready;
	logic [31:0] epoch_seconds = '0;
	logic [29:0] nanoseconds = '0;

	logic        date_valid;
	logic        date_ready = 1'b0;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [29:0] nanosecond;

	// Shadow of the offset register, updated on the APB write edge
	logic signed [4:0] offset_model = UTC_OFFSET_RESET;

	// Expected dates, oldest first
	date_t date_q [$];

	// Travels with the epoch payload: a typed expectation for directed rows
	logic  row_typed = 1'b0;
	date_t row_want = '0;

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	epoch_to_calendar_date_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.epoch_valid   (epoch_valid),
		.epoch_ready   (epoch_ready),
		.epoch_seconds (epoch_seconds),
		.nanoseconds   (nanoseconds),
		.date_valid    (date_valid),
		.date_ready    (date_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.nanosecond    (nanosecond)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local civil date for one epoch transaction: shift by the offset, clamp
	// at zero, split days and second of day, then walk years and months
	// with the every-fourth-year leap rule.
	function automatic date_t predict_date(input logic [31:0] secs, input logic [29:0] ns,
			input logic signed [4:0] offset_hours);
		date_t  d;
		longint local_s;
		longint days;
		longint sod;
		int     yr;
		int     mo;
		int     ylen;
		int     mlen;
		local_s = longint'(secs) + longint'(offset_hours) * SECS_PER_HOUR;
		if (local_s < 0)
			local_s = 0;
		days = local_s / SECS_PER_DAY;
		sod  = local_s % SECS_PER_DAY;
		yr   = EPOCH_YEAR;
		ylen = (yr % 4 == 0) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = (yr % 4 == 0) ? 366 : 365;
		end
		mo   = 0;
		mlen = MONTH_DAYS[0];
		while (days >= mlen && mo < 11) begin
			days -= mlen;
			mo++;
			mlen = MONTH_DAYS[mo] + ((mo == 1 && yr % 4 == 0) ? 1 : 0);
		end
		d.year       = 12'(yr);
		d.month      = 4'(mo + 1);
		d.day        = 5'(days + 1);
		d.hour       = 5'(sod / SECS_PER_HOUR);
		d.minute     = 6'((sod % SECS_PER_HOUR) / 60);
		d.second     = 6'(sod % 60);
		d.nanosecond = ns;
		return d;
	endfunction

	// Random epoch: four in ten uniform, the rest aimed at the clamp region, day,
	// year and month rollovers, the 2100 boundary and the top of the 32-bit range.
	function automatic logic [31:0] pick_epoch();
		longint base;
		longint jitter;
		int     yr;
		jitter = longint'($urandom_range(0, 2 * SECS_PER_DAY)) - SECS_PER_DAY;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4: return $urandom_range(0, 200000);
			5, 6: begin
				yr   = $urandom_range(1970, 2106);
				base = longint'((yr - 1970) * 365 + (yr - 1969) / 4) * SECS_PER_DAY;
				base += longint'(YEAR_MARK_DAYS[$urandom_range(0, 4)]) * SECS_PER_DAY;
				return 32'(base + jitter);
			end
			7: return 32'hFFFFFFFF - $urandom_range(0, 2000000);
			8: return 32'(64'd4102444800 + jitter);
			default: begin
				base = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
				return 32'(base + jitter);
			end
		endcase
	endfunction

	// Holds one epoch transaction until accepted; leaves valid high so the
	// next item can follow back to back. Returns on the falling edge.
	task automatic send_epoch(input logic [31:0] secs, input logic [29:0] ns,
			input logic typed, input date_t want);
		epoch_valid   = 1'b1;
		epoch_seconds = secs;
		nanoseconds   = ns;
		row_typed     = typed;
		row_want      = want;
		do
			@(posedge clk);
		while (!epoch_ready);
		@(negedge clk);
	endtask

	// Bursts of back-to-back items, random gaps between bursts
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			epoch_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(0, 8);
		end
	endtask

	// Stop sending until every expected date is back, then let the pipe settle
	task automatic drain();
		epoch_valid = 1'b0;
		while (date_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	// APB write of the offset register, then a read-back of the same address
	task automatic set_utc_offset(input logic signed [4:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = REG_UTC_OFFSET_ADDR;
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[4:0] !== value) begin
			$error("utc_offset_hours: expected %0d, got %0d", value, $signed(prdata[4:0]));
			fail_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Scoreboard: one process owns the expectation queue, so pushes and pops
	// in the same clock never race. Register writes only happen while idle.
	always @(posedge clk) begin
		date_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == REG_UTC_OFFSET_ADDR)
				offset_model = pwdata[4:0];
			if (epoch_valid && epoch_ready)
				date_q.push_back(row_typed ? row_want
				                           : predict_date(epoch_seconds, nanoseconds,
				                                          offset_model));
			if (date_valid && date_ready) begin
				if (date_q.size() == 0) begin
					$error("date transaction with no expected date pending");
					fail_count++;
				end else begin
					want = date_q.pop_front();
					if (year !== want.year) begin
						$error("year: expected %0d, got %0d", want.year, year);
						fail_count++;
					end
					if (month !== want.month) begin
						$error("month: expected %0d, got %0d", want.month, month);
						fail_count++;
					end
					if (day !== want.day) begin
						$error("day: expected %0d, got %0d", want.day, day);
						fail_count++;
					end
					if (hour !== want.hour) begin
						$error("hour: expected %0d, got %0d", want.hour, hour);
						fail_count++;
					end
					if (minute !== want.minute) begin
						$error("minute: expected %0d, got %0d", want.minute, minute);
						fail_count++;
					end
					if (second !== want.second) begin
						$error("second: expected %0d, got %0d", want.second, second);
						fail_count++;
					end
					if (nanosecond !== want.nanosecond) begin
						$error("nanosecond: expected %0d, got %0d", want.nanosecond,
						       nanosecond);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output back-pressure: free-flowing stretches, coin-flip stretches,
	// hard stalls and mostly-ready stretches, in random order.
	initial begin
		int n;
		forever begin
			case ($urandom_range(0, 3))
				0: begin
					n = $urandom_range(20, 150);
					repeat (n) begin
						@(negedge clk);
						date_ready = 1'b1;
					end
				end
				1: begin
					n = $urandom_range(10, 80);
					repeat (n) begin
						@(negedge clk);
						date_ready = $urandom_range(0, 1);
					end
				end
				2: begin
					n = $urandom_range(1, 30);
					repeat (n) begin
						@(negedge clk);
						date_ready = 1'b0;
					end
				end
				default: begin
					n = $urandom_range(10, 60);
					repeat (n) begin
						@(negedge clk);
						date_ready = ($urandom_range(0, 3) != 0);
					end
				end
			endcase
		end
	end

	initial begin
		dir_row_t          row;
		date_t             want;
		logic [29:0]       ns;
		logic signed [4:0] phase_offset;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows; the first ones run on the reset offset untouched
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.offset != offset_model) begin
				drain();
				set_utc_offset(row.offset);
			end
			want = '{row.y, row.mo, row.d, row.h, row.mi, row.s, row.ns};
			send_epoch(row.secs, row.ns, row.typed, want);
			pace_sender();
		end

		// Random phases, each on its own offset; one phase picks any 5-bit value
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: phase_offset = -5'sd4;
				1: phase_offset = 5'sd15;
				2: phase_offset = -5'sd16;
				3: phase_offset = 5'($urandom_range(0, 31));
				4: phase_offset = -5'sd12;
				default: phase_offset = 5'sd14;
			endcase
			drain();
			set_utc_offset(phase_offset);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				case ($urandom_range(0, 9))
					0: ns = 30'd999999999;
					1: ns = $urandom_range(0, 1) ? 30'h3FFFFFFF : 30'd0;
					default: ns = 30'($urandom());
				endcase
				send_epoch(pick_epoch(), ns, 1'b0, '0);
				// mid-phase hold-off until the pipe is empty
				if (p == 0 && k == ITEMS_PER_PHASE / 2)
					drain();
				else
					pace_sender();
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/e2cd_pkg.sv
rtl/core/e2cd_pipe.sv
rtl/core/epoch_to_calendar_date_top.sv
sim/tb_epoch_to_calendar_date_top.sv
